### rtl/hsd_pkg.sv
// Shared constants and types for the header sync packet deframer.
package hsd_pkg;

  localparam int FrameLen = 6;
  localparam int CountW = 3;
  localparam logic [7:0] HdrFirst = 8'hFF;
  localparam logic [7:0] HdrSecond = 8'h55;

  typedef logic [7:0] byte_t;
  typedef logic [CountW-1:0] count_t;
  typedef byte_t [FrameLen-1:0] frame_t;

  // One received byte held in the input register.
  typedef struct packed {
    logic valid;
    byte_t data;
  } byte_beat_t;

  // Outcome of processing one byte.
  typedef struct packed {
    logic emit;
    logic [15:0] word;
  } result_t;

endpackage

### rtl/hsd_in_stage.sv
// Input register that holds one received byte until the frame logic takes it.
module hsd_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          rx_byte,
  input  logic                advance,
  output hsd_pkg::byte_beat_t beat
);

  logic       valid;
  logic [7:0] data;

  // The register frees up whenever its content moves on in this cycle.
  assign in_ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= rx_byte;
    end
  end

  assign beat.valid = valid;
  assign beat.data  = data;

endmodule

### rtl/hsd_deframe.sv
// Frame buffer, header search and shift, and complement check of a full frame.
module hsd_deframe (
  input  logic                clk,
  input  logic                rst,
  input  hsd_pkg::byte_beat_t beat,
  input  logic                advance,
  output hsd_pkg::result_t    result
);

  hsd_pkg::frame_t frame;
  hsd_pkg::frame_t frame_next;
  hsd_pkg::count_t count;
  hsd_pkg::count_t count_next;

  always_comb begin
    hsd_pkg::frame_t w;
    hsd_pkg::frame_t shifted;
    hsd_pkg::count_t n;
    hsd_pkg::count_t sh;
    hsd_pkg::count_t count_mid;
    logic [hsd_pkg::CountW:0] idx;
    logic found;
    logic full;
    logic ok;

    w = frame;
    w[count] = beat.data;
    n = count + hsd_pkg::CountW'(1);
    found = 1'b0;
    sh = '0;

    // With two or more bytes, find the first header pair; without one, keep only a trailing first header byte.
    if (n >= hsd_pkg::CountW'(2)) begin
      for (int i = 0; i < hsd_pkg::FrameLen - 1; i++) begin
        if (!found && w[i] == hsd_pkg::HdrFirst && w[i+1] == hsd_pkg::HdrSecond &&
            hsd_pkg::CountW'(i + 1) < n) begin
          found = 1'b1;
          sh = hsd_pkg::CountW'(i);
        end
      end
      if (!found) begin
        sh = (beat.data == hsd_pkg::HdrFirst) ? count : n;
      end
    end

    for (int j = 0; j < hsd_pkg::FrameLen; j++) begin
      idx = (hsd_pkg::CountW + 1)'(j) + {1'b0, sh};
      shifted[j] = (idx < {1'b0, n}) ? w[idx[hsd_pkg::CountW-1:0]] : '0;
    end

    count_mid = n - sh;
    full = (count_mid == hsd_pkg::CountW'(hsd_pkg::FrameLen));
    ok = shifted[0] == hsd_pkg::HdrFirst && shifted[1] == hsd_pkg::HdrSecond &&
         shifted[2] == ~shifted[3] && shifted[4] == ~shifted[5];

    frame_next  = full ? '0 : shifted;
    count_next  = full ? '0 : count_mid;
    result.emit = beat.valid && full && ok;
    result.word = {shifted[4], shifted[2]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      frame <= '0;
    end else if (beat.valid && advance) begin
      count <= count_next;
      frame <= frame_next;
    end
  end

endmodule

### rtl/header_sync_packet_deframer.sv
// Header sync packet deframer: one received byte per beat goes into a six-byte frame
// buffer that is realigned on every beat to the header pair 0xFF 0x55; a full frame
// whose third byte is the complement of the fourth and whose fifth byte is the
// complement of the sixth yields one 16-bit word (fifth byte high, third byte low),
// and every full frame empties the buffer. The block takes one beat per clock cycle
// for as long as results are taken: the header search, shift and check are a single
// pass of parallel compares over the six buffer entries, so a byte is done while it
// sits in the input register. A result passes from the input register through the
// frame logic into the output register before it shows. A result waiting in
// the output register holds back the frame logic, and the input register then
// absorbs at most one more beat before in_ready drops.
module header_sync_packet_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] rx_word
);

  hsd_pkg::byte_beat_t beat;
  hsd_pkg::result_t    result;
  logic                advance;

  // The frame logic moves whenever the output register is empty or being drained.
  assign advance = !out_valid || out_ready;

  hsd_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .beat     (beat)
  );

  hsd_deframe u_deframe (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .advance (advance),
    .result  (result)
  );

  // Output register. It loads a word only when a frame passes its checks.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      rx_word <= result.word;
    end
  end

endmodule

### rtl/hsd_checker.sv
// Port-level checks for the header sync packet deframer, bound to the top level.
module hsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] rx_word
);

  // Reset leaves no result pending.
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A stalled result keeps its word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(rx_word))
    else $error("stalled result changed");

  // With the output free or draining, the block always takes a beat.
  assert property (@(posedge clk) (!out_valid || out_ready) |-> in_ready)
    else $error("input blocked while output can move");

  // A new result comes from a beat that was accepted and then passed the input and output registers.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a completing beat");

endmodule

bind header_sync_packet_deframer hsd_checker u_hsd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .rx_word   (rx_word)
);
